// File: hw/rtl/afpa_pkg.sv
// Shared types and constants for the audio frame pacing accumulator.
`default_nettype none
package afpa_pkg;

    // Field and register widths
    localparam int KIND_W    = 2;
    localparam int TS_W      = 64;
    localparam int FRAMES_W  = 8;
    localparam int CREDIT_W  = 32;
    localparam int RATE_W    = 17;
    localparam int BITS_W    = 5;
    localparam int IVAL_W    = 5;
    localparam int BLOCK_W   = 11;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    // Serial arithmetic
    localparam int OP_W      = 32;
    localparam int DVD_W     = 64;
    localparam int QUO_W     = 32;
    localparam int STEP_W    = 7;
    localparam int MSTEP_W   = 6;
    localparam int IUS_W     = 15;
    localparam int RB_W      = 22;

    localparam logic [STEP_W-1:0]  STEPS_SHORT = 7'd32;
    localparam logic [STEP_W-1:0]  STEPS_LONG  = 7'd64;
    localparam logic [MSTEP_W-1:0] MUL_STEPS   = 6'd32;
    localparam int                 MS_TO_US    = 1000;
    localparam int                 MS_PER_S    = 1000;
    localparam logic [FRAMES_W-1:0] FRAMES_MAX = 8'd255;

    // Register reset values
    localparam logic [RATE_W-1:0]  RATE_RST  = 17'd44100;
    localparam logic [BITS_W-1:0]  BITS_RST  = 5'd16;
    localparam logic [IVAL_W-1:0]  IVAL_RST  = 5'd20;
    localparam logic [BLOCK_W-1:0] BLOCK_RST = 11'd512;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_RESET = 2'd1,
        KIND_FLUSH = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        REG_RATE     = 2'd0,
        REG_BITS     = 2'd1,
        REG_INTERVAL = 2'd2,
        REG_BLOCK    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [RATE_W-1:0]  sample_rate_hz;
        logic [BITS_W-1:0]  sample_bits;
        logic [IVAL_W-1:0]  interval_millis;
        logic [BLOCK_W-1:0] block_samples;
    } t_cfg;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_div_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RST_MUL,
        ST_RST_SCALE,
        ST_RST_DSTART,
        ST_RST_DIV,
        ST_TICK_PREP,
        ST_TICK_MSTART,
        ST_TICK_MUL,
        ST_TICK_GSTART,
        ST_TICK_GDIV,
        ST_TICK_ADD,
        ST_TICK_FSTART,
        ST_TICK_FDIV,
        ST_RESULT
    } t_state;

endpackage
`default_nettype wire

// File: hw/rtl/afpa_if.sv
// Valid/ready channel interfaces for the input items and the results.
`default_nettype none
interface afpa_in_if;
    logic                          valid;
    logic                          ready;
    logic [afpa_pkg::KIND_W-1:0]   kind;
    logic [afpa_pkg::TS_W-1:0]     stamp_usec;

    modport source (output valid, kind, stamp_usec, input ready);
    modport sink   (input valid, kind, stamp_usec, output ready);
endinterface

interface afpa_out_if;
    logic                          valid;
    logic                          ready;
    logic [afpa_pkg::FRAMES_W-1:0] frames_due;
    logic [afpa_pkg::CREDIT_W-1:0] credit_bytes;

    modport source (output valid, frames_due, credit_bytes, input ready);
    modport sink   (input valid, frames_due, credit_bytes, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/audio_frame_pacing_accumulator.sv
// Audio frame pacing accumulator: top level with the item sequencer.
//
// Input channel i_in carries kind and a microsecond timestamp; each transfer
// gives exactly one result transfer on o_out (frames_due, credit_bytes).
// Kind 0 is a tick, 1 a feeding reset, 2 a credit flush, 3 is ignored.
// Registers are to be written over the APB-style port only while the block
// is idle; the block itself does not enforce this. One item is worked at a
// time; i_in.ready is high only in the idle state, so the next item is taken
// in the cycle after the previous result is loaded. A tick passes through
// the bit-serial multiply of bytes per interval by elapsed time, the 64-step
// division by the interval in microseconds, the 32-step division by the
// frame size and sequencing states; with a zero interval the growth division
// is skipped. A feeding reset runs a 32-step divide by 1000, skipped with a
// zero interval; flush and ignored kinds, and a tick with a zero frame size,
// go straight to the result. A stalled receiver holds the sequencer in its
// last step until the output register frees, and i_in.ready stays low
// meanwhile. Reset clears credit, last timestamp and bytes per interval, and
// loads the register defaults.
`default_nettype none
module audio_frame_pacing_accumulator #(
    parameter int CHANNEL_COUNT = 2
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    afpa_in_if.sink                            i_in,
    afpa_out_if.source                         o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [afpa_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [afpa_pkg::DATA_W-1:0]   pwdata,
    output      logic [afpa_pkg::DATA_W-1:0]   prdata,
    output      logic                          pready
);

    localparam int CH_W      = $clog2(CHANNEL_COUNT + 1);
    localparam int FB_PROD_W = afpa_pkg::BLOCK_W + afpa_pkg::BITS_W + CH_W;
    localparam int FB_W      = FB_PROD_W - 3;
    localparam int DIV_W     = (FB_W > afpa_pkg::IUS_W) ? FB_W : afpa_pkg::IUS_W;
    localparam int CW        = afpa_pkg::CREDIT_W;
    localparam int TW        = afpa_pkg::TS_W;

    afpa_pkg::t_cfg         cfg;
    afpa_pkg::t_state       r_state, n_state;
    afpa_pkg::t_div_stat    div_stat;

    logic [CW-1:0]          r_credit;
    logic [TW-1:0]          r_last;
    logic [CW-1:0]          r_bpi;
    logic [TW-1:0]          r_ts;
    logic [CW-1:0]          r_elapsed;
    logic [FB_W-1:0]        r_fbytes;
    logic [CW-1:0]          r_work;
    logic [afpa_pkg::FRAMES_W-1:0] r_frames;
    logic                   r_out_valid;
    logic [afpa_pkg::FRAMES_W-1:0] r_out_frames;
    logic [CW-1:0]          r_out_credit;

    logic                   out_free;
    logic                   accept;
    logic [FB_PROD_W-1:0]   fb_prod;
    logic [FB_W-1:0]        fb;
    logic [afpa_pkg::IUS_W-1:0] ival_usec;
    logic [TW:0]            ts_diff;
    logic                   ts_adv;
    logic [CW-1:0]          elapsed;
    logic [CW:0]            credit_sum;

    logic                   mul_start;
    logic                   mul_done;
    logic [2*afpa_pkg::OP_W-1:0] mul_prod;

    logic                   div_start;
    logic [afpa_pkg::STEP_W-1:0] div_steps;
    logic [afpa_pkg::DVD_W-1:0]  div_dividend;
    logic [DIV_W-1:0]       div_divisor;
    logic [afpa_pkg::QUO_W-1:0]  div_quot;
    logic [DIV_W-1:0]       div_rem;

    afpa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    afpa_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_bpi),
        .i_b     (r_elapsed),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    afpa_div #(
        .DVS_W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_steps    (div_steps),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign fb_prod = FB_PROD_W'(cfg.block_samples) * FB_PROD_W'(cfg.sample_bits)
                   * FB_PROD_W'(CHANNEL_COUNT);
    assign fb      = fb_prod[FB_PROD_W-1:3];
    assign ival_usec = afpa_pkg::IUS_W'(cfg.interval_millis)
                     * afpa_pkg::IUS_W'(afpa_pkg::MS_TO_US);

    // elapsed time: one interval unless a stored stamp exists and time moved forward
    assign ts_diff = {1'b0, r_ts} - {1'b0, r_last};
    assign ts_adv  = (r_last != '0) && !ts_diff[TW] && (ts_diff[TW-1:0] != '0);
    assign elapsed = !ts_adv ? CW'(ival_usec)
                   : (|ts_diff[TW-1:CW]) ? {CW{1'b1}} : ts_diff[CW-1:0];

    assign credit_sum = {1'b0, r_credit} + {1'b0, r_work};

    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == afpa_pkg::ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    assign o_out.valid        = r_out_valid;
    assign o_out.frames_due   = r_out_frames;
    assign o_out.credit_bytes = r_out_credit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= afpa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        mul_start    = 1'b0;
        div_start    = 1'b0;
        div_steps    = afpa_pkg::STEPS_SHORT;
        div_dividend = {r_work, {CW{1'b0}}};
        div_divisor  = DIV_W'(afpa_pkg::MS_PER_S);
        unique case (r_state)
            afpa_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (afpa_pkg::t_kind'(i_in.kind))
                        afpa_pkg::KIND_TICK:  n_state = afpa_pkg::ST_TICK_PREP;
                        afpa_pkg::KIND_RESET: n_state = (cfg.interval_millis != '0)
                                                      ? afpa_pkg::ST_RST_MUL
                                                      : afpa_pkg::ST_RESULT;
                        default:              n_state = afpa_pkg::ST_RESULT;
                    endcase
                end
            end
            afpa_pkg::ST_RST_MUL:    n_state = afpa_pkg::ST_RST_SCALE;
            afpa_pkg::ST_RST_SCALE:  n_state = afpa_pkg::ST_RST_DSTART;
            afpa_pkg::ST_RST_DSTART: begin
                div_start = 1'b1;
                n_state   = afpa_pkg::ST_RST_DIV;
            end
            afpa_pkg::ST_RST_DIV: begin
                if (div_stat.done) n_state = afpa_pkg::ST_RESULT;
            end
            afpa_pkg::ST_TICK_PREP: begin
                n_state = (fb == '0) ? afpa_pkg::ST_RESULT : afpa_pkg::ST_TICK_MSTART;
            end
            afpa_pkg::ST_TICK_MSTART: begin
                mul_start = 1'b1;
                n_state   = afpa_pkg::ST_TICK_MUL;
            end
            afpa_pkg::ST_TICK_MUL: begin
                if (mul_done) begin
                    n_state = (ival_usec == '0) ? afpa_pkg::ST_TICK_ADD
                                                : afpa_pkg::ST_TICK_GSTART;
                end
            end
            afpa_pkg::ST_TICK_GSTART: begin
                div_start    = 1'b1;
                div_steps    = afpa_pkg::STEPS_LONG;
                div_dividend = mul_prod;
                div_divisor  = DIV_W'(ival_usec);
                n_state      = afpa_pkg::ST_TICK_GDIV;
            end
            afpa_pkg::ST_TICK_GDIV: begin
                if (div_stat.done) n_state = afpa_pkg::ST_TICK_ADD;
            end
            afpa_pkg::ST_TICK_ADD:   n_state = afpa_pkg::ST_TICK_FSTART;
            afpa_pkg::ST_TICK_FSTART: begin
                div_start    = 1'b1;
                div_dividend = {r_credit, {CW{1'b0}}};
                div_divisor  = DIV_W'(r_fbytes);
                n_state      = afpa_pkg::ST_TICK_FDIV;
            end
            afpa_pkg::ST_TICK_FDIV: begin
                if (div_stat.done) n_state = afpa_pkg::ST_RESULT;
            end
            afpa_pkg::ST_RESULT: begin
                if (out_free) n_state = afpa_pkg::ST_IDLE;
            end
            default: n_state = afpa_pkg::ST_IDLE;
        endcase
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
            r_last   <= '0;
            r_bpi    <= '0;
        end else begin
            case (r_state)
                afpa_pkg::ST_IDLE: begin
                    if (accept) begin
                        if (i_in.kind == afpa_pkg::KIND_RESET) begin
                            r_credit <= '0;
                            r_last   <= '0;
                        end else if (i_in.kind == afpa_pkg::KIND_FLUSH) begin
                            r_credit <= '0;
                        end
                    end
                end
                afpa_pkg::ST_RST_DIV: begin
                    if (div_stat.done) r_bpi <= div_quot;
                end
                afpa_pkg::ST_TICK_PREP: begin
                    if (fb != '0) r_last <= r_ts;
                end
                afpa_pkg::ST_TICK_ADD: begin
                    r_credit <= credit_sum[CW] ? {CW{1'b1}} : credit_sum[CW-1:0];
                end
                afpa_pkg::ST_TICK_FDIV: begin
                    if (div_stat.done) r_credit <= CW'(div_rem);
                end
                default: r_credit <= r_credit;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            afpa_pkg::ST_IDLE: begin
                if (accept) begin
                    r_ts     <= i_in.stamp_usec;
                    r_frames <= '0;
                end
            end
            afpa_pkg::ST_RST_MUL: begin
                r_work <= CW'(afpa_pkg::RB_W'(cfg.sample_rate_hz)
                            * afpa_pkg::RB_W'(cfg.sample_bits));
            end
            afpa_pkg::ST_RST_SCALE: begin
                r_work <= CW'(r_work[afpa_pkg::RB_W-1:3]) * CW'(CHANNEL_COUNT)
                        * CW'(cfg.interval_millis);
            end
            afpa_pkg::ST_TICK_PREP: begin
                r_elapsed <= elapsed;
                r_fbytes  <= fb;
            end
            afpa_pkg::ST_TICK_MUL: begin
                if (mul_done) r_work <= '0;
            end
            afpa_pkg::ST_TICK_GDIV: begin
                if (div_stat.done) r_work <= div_stat.ovf ? {CW{1'b1}} : div_quot;
            end
            afpa_pkg::ST_TICK_FDIV: begin
                if (div_stat.done) begin
                    r_frames <= (|div_quot[afpa_pkg::QUO_W-1:afpa_pkg::FRAMES_W])
                              ? afpa_pkg::FRAMES_MAX : div_quot[afpa_pkg::FRAMES_W-1:0];
                end
            end
            default: r_work <= r_work;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == afpa_pkg::ST_RESULT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == afpa_pkg::ST_RESULT && out_free) begin
            r_out_frames <= r_frames;
            r_out_credit <= r_credit;
        end
    end

`ifndef NO_ASSERTIONS
    a_frames_leave_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.frames_due != '0) |-> (o_out.credit_bytes < CW'(r_fbytes)))
        else $error("frames reported while a whole frame remains in credit");

    a_mul_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == afpa_pkg::ST_TICK_MUL))
        else $error("multiplier finished outside its wait state");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == afpa_pkg::ST_RST_DIV
                        || r_state == afpa_pkg::ST_TICK_GDIV
                        || r_state == afpa_pkg::ST_TICK_FDIV))
        else $error("divider finished outside a divide wait state");

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input taken while an item is in progress");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/afpa_cfg.sv
// APB-style configuration register file.
`default_nettype none
module afpa_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [afpa_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [afpa_pkg::DATA_W-1:0]   pwdata,
    output      logic [afpa_pkg::DATA_W-1:0]   prdata,
    output      logic                          pready,
    output      afpa_pkg::t_cfg                o_cfg
);

    afpa_pkg::t_cfg     r_cfg;
    afpa_pkg::t_reg_idx idx;
    logic               wr_en;

    assign idx    = afpa_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_rate_hz  <= afpa_pkg::RATE_RST;
            r_cfg.sample_bits     <= afpa_pkg::BITS_RST;
            r_cfg.interval_millis <= afpa_pkg::IVAL_RST;
            r_cfg.block_samples   <= afpa_pkg::BLOCK_RST;
        end else if (wr_en) begin
            unique case (idx)
                afpa_pkg::REG_RATE:     r_cfg.sample_rate_hz  <= pwdata[afpa_pkg::RATE_W-1:0];
                afpa_pkg::REG_BITS:     r_cfg.sample_bits     <= pwdata[afpa_pkg::BITS_W-1:0];
                afpa_pkg::REG_INTERVAL: r_cfg.interval_millis <= pwdata[afpa_pkg::IVAL_W-1:0];
                afpa_pkg::REG_BLOCK:    r_cfg.block_samples   <= pwdata[afpa_pkg::BLOCK_W-1:0];
                default:                r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            afpa_pkg::REG_RATE:     prdata = afpa_pkg::DATA_W'(r_cfg.sample_rate_hz);
            afpa_pkg::REG_BITS:     prdata = afpa_pkg::DATA_W'(r_cfg.sample_bits);
            afpa_pkg::REG_INTERVAL: prdata = afpa_pkg::DATA_W'(r_cfg.interval_millis);
            afpa_pkg::REG_BLOCK:    prdata = afpa_pkg::DATA_W'(r_cfg.block_samples);
            default:                prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: hw/rtl/afpa_mul.sv
// Bit-serial 32x32 shift-add multiplier, one multiplier bit per cycle.
`default_nettype none
module afpa_mul (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [afpa_pkg::OP_W-1:0]     i_a,
    input  wire logic [afpa_pkg::OP_W-1:0]     i_b,
    output      logic                          o_done,
    output      logic [2*afpa_pkg::OP_W-1:0]   o_prod
);

    localparam int W = afpa_pkg::OP_W;

    logic [2*W-1:0]                 r_acc;
    logic [W-1:0]                   r_a;
    logic [afpa_pkg::MSTEP_W-1:0]   r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [W:0]                     sum;

    // upper half picks up the multiplicand when the current low bit is set
    assign sum    = {1'b0, r_acc[2*W-1:W]} + (r_acc[0] ? {1'b0, r_a} : {(W+1){1'b0}});
    assign o_done = r_done;
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= afpa_pkg::MUL_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == afpa_pkg::MSTEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_acc <= {{W{1'b0}}, i_b};
        end else if (r_busy) begin
            r_acc <= {sum, r_acc[W-1:1]};
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/afpa_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, saturation flag.
`default_nettype none
module afpa_div #(
    parameter int DVS_W = 15
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [afpa_pkg::STEP_W-1:0]   i_steps,
    input  wire logic [afpa_pkg::DVD_W-1:0]    i_dividend,
    input  wire logic [DVS_W-1:0]              i_divisor,
    output      afpa_pkg::t_div_stat           o_stat,
    output      logic [afpa_pkg::QUO_W-1:0]    o_quot,
    output      logic [DVS_W-1:0]              o_rem
);

    localparam int DW = afpa_pkg::DVD_W;
    localparam int QW = afpa_pkg::QUO_W;

    logic [DW-1:0]                  r_dvd;
    logic [DVS_W-1:0]               r_dvs;
    logic [DVS_W-1:0]               r_rem;
    logic [QW-1:0]                  r_quot;
    logic                           r_ovf;
    logic [afpa_pkg::STEP_W-1:0]    r_cnt;
    logic                           r_busy;
    logic                           r_done;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           ge;

    assign trial = {r_rem, r_dvd[DW-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    assign o_stat.done = r_done;
    assign o_stat.ovf  = r_ovf;
    assign o_quot      = r_quot;
    assign o_rem       = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == afpa_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= i_dividend;
            r_dvs  <= i_divisor;
            r_rem  <= '0;
            r_quot <= '0;
            r_ovf  <= 1'b0;
        end else if (r_busy) begin
            r_dvd  <= {r_dvd[DW-2:0], 1'b0};
            r_rem  <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            r_quot <= {r_quot[QW-2:0], ge};
            // any quotient bit pushed past the top sets the overflow flag
            r_ovf  <= r_ovf | r_quot[QW-1];
        end
    end

endmodule
`default_nettype wire
